// ===== rtl/single_wire_uart_with_rx_fifo_top_assert.svh =====
// Assertion macros used by the checker file of the serial port.
`ifndef SINGLE_WIRE_UART_WITH_RX_FIFO_TOP_ASSERT_SVH
`define SINGLE_WIRE_UART_WITH_RX_FIFO_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SWU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define SWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swuart_pkg.sv =====
// Types and constants of the single-wire serial port with receive FIFO.
package swuart_pkg;

  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [19:0] BIT_TIME_RST = 20'd25000;
  localparam logic [15:0] LAT_COMP_RST = 16'd500;
  localparam logic [19:0] TICKS_MS_RST = 20'd240000;

  // x/3 == (x * THIRD_MUL) >> THIRD_SHIFT for every 20-bit x
  localparam logic [19:0] THIRD_MUL   = 20'd699051;
  localparam int unsigned THIRD_SHIFT = 21;

  localparam logic [3:0] DATA_BITS  = 4'd8;
  localparam logic [3:0] FRAME_BITS = 4'd10;

  localparam int unsigned Q_DEPTH = 3;

  typedef enum logic [1:0] {
    CFG_BIT_TIME = 2'd0,
    CFG_LAT_COMP = 2'd1,
    CFG_TICKS_MS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_TX    = 3'd1,
    OP_RX    = 3'd2,
    OP_READ  = 3'd3,
    OP_PEEK  = 3'd4,
    OP_FLUSH = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TX     = 3'd1,
    PH_WAIT   = 3'd2,
    PH_SAMPLE = 3'd3,
    PH_STOP   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_STORED  = 2'd1,
    EV_DROPPED = 2'd2,
    EV_TIMEOUT = 2'd3
  } rx_ev_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic        line_in;
    logic [7:0]  tx_byte;
    logic [15:0] timeout_ms;
  } swuart_in_t;

  typedef struct packed {
    logic       line_out;
    logic       line_drive;
    logic [7:0] read_data;
    logic       read_valid;
    logic [1:0] rx_event;
    logic [5:0] fill_count;
    logic       overflow_flag;
    logic       busy_res;
  } swuart_out_t;

endpackage

// ===== rtl/swuart_mem.sv =====
// Receive byte store: one write port, one read port with registered data.
module swuart_mem #(
  parameter int unsigned FIFO_DEPTH = 64,
  parameter int unsigned IDX_W      = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/swuart_ctrl.sv =====
// Bit timer, phase machine, FIFO indices and configuration registers.
module swuart_ctrl #(
  parameter int unsigned FIFO_DEPTH = 64,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swuart_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [swuart_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                                 in_acc_i,
  input  swuart_pkg::swuart_in_t               in_data_i,
  output logic                                 res_valid_o,
  output swuart_pkg::swuart_out_t              res_o,
  output logic                                 mem_we_o,
  output logic [IDX_W-1:0]                     mem_waddr_o,
  output logic [7:0]                           mem_wdata_o,
  output logic                                 mem_re_o,
  output logic [IDX_W-1:0]                     mem_raddr_o
);

  import swuart_pkg::*;

  localparam int unsigned FW = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
    return (v == IDX_W'(FIFO_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  // configuration
  logic [19:0] bit_time_q, tpms_q;
  logic [15:0] lat_q;
  logic [39:0] third_prod;
  logic [18:0] third_q;
  logic [20:0] fd_sum, fd_d, fd_q;
  logic [19:0] bt, tpm;

  // item state
  phase_e          phase_q, phase_d;
  logic            lii_q, lii_d;
  logic [20:0]     tc_q, tc_d;
  logic [16:0]     ms_q, ms_d;
  logic [3:0]      bi_q, bi_d;
  logic [7:0]      sb_q, sb_d;
  logic [15:0]     tl_q, tl_d;
  logic [IDX_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic            ovf_q, ovf_d;
  logic            fresh, rvalid, lout;
  rx_ev_e          ev;
  logic [20:0]     thr;
  logic [2:0]      tx_sel;
  logic [FW-1:0]   fill;
  logic            res_valid_q;
  swuart_out_t     res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q <= BIT_TIME_RST;
      lat_q      <= LAT_COMP_RST;
      tpms_q     <= TICKS_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BIT_TIME: bit_time_q <= cfg_wdata_i;
        CFG_LAT_COMP: lat_q      <= cfg_wdata_i[15:0];
        CFG_TICKS_MS: tpms_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // first sample delay, two register steps behind the config registers
  assign third_prod = bit_time_q * THIRD_MUL;
  assign fd_sum     = 21'(bit_time_q) + 21'(third_q);
  assign fd_d       = (fd_sum > 21'(lat_q)) ? fd_sum - 21'(lat_q) : 21'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      third_q <= '0;
      fd_q    <= 21'd1;
    end else begin
      third_q <= third_prod[THIRD_SHIFT +: 19];
      fd_q    <= fd_d;
    end
  end

  assign bt  = (bit_time_q == '0) ? 20'd1 : bit_time_q;
  assign tpm = (tpms_q == '0) ? 20'd1 : tpms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      lii_q       <= 1'b1;
      tc_q        <= '0;
      ms_q        <= '0;
      bi_q        <= '0;
      sb_q        <= '0;
      tl_q        <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      lii_q       <= lii_d;
      tc_q        <= tc_d;
      ms_q        <= ms_d;
      bi_q        <= bi_d;
      sb_q        <= sb_d;
      tl_q        <= tl_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      ovf_q       <= ovf_d;
      res_valid_q <= in_acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    lii_d       = lii_q;
    tc_d        = tc_q;
    ms_d        = ms_q;
    bi_d        = bi_q;
    sb_d        = sb_q;
    tl_d        = tl_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    ovf_d       = ovf_q;
    fresh       = 1'b0;
    rvalid      = 1'b0;
    ev          = EV_NONE;
    thr         = fd_q;
    wr_next     = idx_inc(wr_q);
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_wdata_o = sb_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_q;

    if (in_acc_i) begin
      if (phase_q == PH_IDLE) begin
        unique case (op_e'(in_data_i.operation))
          OP_TX: begin
            lii_d   = 1'b0;
            sb_d    = in_data_i.tx_byte;
            bi_d    = '0;
            tc_d    = '0;
            phase_d = PH_TX;
            fresh   = 1'b1;
          end
          OP_RX: begin
            lii_d   = 1'b1;
            tl_d    = in_data_i.timeout_ms;
            tc_d    = '0;
            ms_d    = '0;
            phase_d = PH_WAIT;
          end
          OP_READ, OP_PEEK: begin
            if (wr_q != rd_q) begin
              rvalid   = 1'b1;
              mem_re_o = 1'b1;
              if (op_e'(in_data_i.operation) == OP_READ) begin
                rd_d = idx_inc(rd_q);
              end
            end
          end
          OP_FLUSH: begin
            wr_d = '0;
            rd_d = '0;
          end
          OP_NONE: ;
          default: ;
        endcase
      end

      unique case (phase_d)
        PH_TX: begin
          if (!fresh) begin
            tc_d = tc_d + 21'd1;
            if (tc_d >= 21'(bt)) begin
              tc_d = '0;
              bi_d = bi_d + 4'd1;
              if (bi_d >= FRAME_BITS) begin
                bi_d    = '0;
                phase_d = PH_IDLE;
              end
            end
          end
        end
        PH_WAIT: begin
          if (!in_data_i.line_in) begin
            phase_d = PH_SAMPLE;
            tc_d    = '0;
            bi_d    = '0;
            sb_d    = '0;
          end else begin
            tc_d = tc_d + 21'd1;
            if (tc_d >= 21'(tpm)) begin
              tc_d = '0;
              ms_d = ms_d + 17'd1;
            end
            if (ms_d > 17'(tl_d)) begin
              ev      = EV_TIMEOUT;
              tc_d    = '0;
              ms_d    = '0;
              phase_d = PH_IDLE;
            end
          end
        end
        PH_SAMPLE: begin
          tc_d = tc_d + 21'd1;
          thr  = (bi_d == '0) ? fd_q : 21'(bt);
          if (tc_d >= thr) begin
            tc_d = '0;
            sb_d = {in_data_i.line_in, sb_d[7:1]};
            bi_d = bi_d + 4'd1;
            if (bi_d >= DATA_BITS) begin
              bi_d    = '0;
              phase_d = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          tc_d = tc_d + 21'd1;
          if (tc_d >= 21'(bt)) begin
            tc_d = '0;
            if (wr_next != rd_d) begin
              mem_we_o = 1'b1;
              wr_d     = wr_next;
              ev       = EV_STORED;
            end else begin
              ovf_d = 1'b1;
              ev    = EV_DROPPED;
            end
            phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // transmit line level: start bit, data LSB first, stop bit
  assign tx_sel = 3'(bi_d - 4'd1);

  always_comb begin
    lout = 1'b1;
    if (phase_d == PH_TX && !lii_d) begin
      if (bi_d == '0) begin
        lout = 1'b0;
      end else if (bi_d <= DATA_BITS) begin
        lout = sb_d[tx_sel];
      end
    end
  end

  assign fill = (wr_d >= rd_d) ? FW'(wr_d) - FW'(rd_d)
                               : FW'(wr_d) + FW'(FIFO_DEPTH) - FW'(rd_d);

  always_comb begin
    res_d               = '0;
    res_d.line_out      = lout;
    res_d.line_drive    = ~lii_d;
    res_d.read_valid    = rvalid;
    res_d.rx_event      = ev;
    res_d.fill_count    = fill[5:0];
    res_d.overflow_flag = ovf_d;
    res_d.busy_res      = (phase_d != PH_IDLE);
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/swuart_outq.sv =====
// Three-entry result queue between the work stage and the output channel.
module swuart_outq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  swuart_pkg::swuart_out_t push_data_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output swuart_pkg::swuart_out_t out_data_o
);

  import swuart_pkg::*;

  swuart_out_t q [Q_DEPTH];
  logic [1:0]  head_q, head_d, tail_q, tail_d, cnt_q, cnt_d;
  logic        pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(Q_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop = (cnt_q != 2'd0) && !out_stall_i;

  // one beat may sit in the work stage; hold off input when it could not land
  assign in_stall_o = (cnt_q == 2'(Q_DEPTH)) || (cnt_q == 2'(Q_DEPTH - 1) && push_i);

  always_comb begin
    head_d = pop ? ptr_inc(head_q) : head_q;
    tail_d = push_i ? ptr_inc(tail_q) : tail_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q[tail_q] <= push_data_i;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = q[head_q];

endmodule

// ===== rtl/single_wire_uart_with_rx_fifo_top.sv =====
// Half-duplex 8N1 serial port on one shared line with a receive byte FIFO.
//
// Input channel: one beat per clock tick of the bit timer, carrying an
// operation (none, transmit, receive, read, peek, flush), the sampled line
// level, the byte to send and the receive timeout in ms. Operations that
// arrive while a transmit or receive runs are ignored.
// Output channel: exactly one result beat per input beat, in order: line
// level and direction, read byte and valid, receive event, FIFO fill count,
// sticky overflow and busy.
// A result is registered in the bit-timer stage, whose FIFO read has registered
// data, and then in the result queue. Throughput: one beat per cycle while the
// output drains. A stalled output fills a three-entry result queue; input is
// stalled once the queue and the work stage together hold three beats.
// Configuration: bit_time, latency_comp, ticks_per_ms, written at any index
// 0..2 while the block is idle, which the user must keep to, as the block
// does not enforce it; the first-sample delay is derived through third_q, fd_q.
// Reset: registers take their defaults, the FIFO is empty, the line is an
// input and no result is pending. Stored bytes need no clearing.
module single_wire_uart_with_rx_fifo_top #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  swuart_pkg::swuart_in_t           in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output swuart_pkg::swuart_out_t          out_data_o,
  input  logic                             cfg_we_i,
  input  logic [swuart_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swuart_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import swuart_pkg::*;

  localparam int unsigned IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic             in_acc;
  logic             res_valid;
  swuart_out_t      res, push_data;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  assign in_acc = in_valid_i && !in_stall_o;

  swuart_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_acc_i    (in_acc),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  swuart_mem #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    push_data           = res;
    push_data.read_data = res.read_valid ? mem_rdata : 8'd0;
  end

  swuart_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (push_data),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/swuart_chk.sv =====
// Port-level checks for the serial port, bound to the top level.
`include "single_wire_uart_with_rx_fifo_top_assert.svh"

module swuart_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input swuart_pkg::swuart_out_t out_data_o
);

  import swuart_pkg::*;

  `SWU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output beat changed")
  `SWU_ASSERT_SAME(a_rdata_zero, out_valid_o && !out_data_o.read_valid, out_data_o.read_data == 8'd0, "read_data set without read_valid")
  `SWU_ASSERT_SAME(a_idle_level, out_valid_o && !out_data_o.line_drive, out_data_o.line_out, "line driven low while released")
  `SWU_ASSERT_SAME(a_event_idle, out_valid_o && out_data_o.rx_event != EV_NONE, !out_data_o.busy_res, "receive event while still busy")

endmodule

bind single_wire_uart_with_rx_fifo_top swuart_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
